### src/rleb_pkg.sv
// ----------------------------------------------------------------------------
// rleb_pkg
// shared types and helpers of the run-length byte encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rleb_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;   // run length, up to 128

    // one decided run, handed from the front to the back
    typedef struct packed {
        logic              rep;        // 1 replicate, 0 literal
        logic [LEN_W-1:0]  len;        // run length in bytes
        logic [BYTE_W-1:0] dat;        // repeated byte
        logic              step_last;  // last run caused by its input item
        logic              fin;        // input item closed the block
    } t_cmd;

    function automatic t_cmd mk_cmd(input logic rep, input logic [LEN_W-1:0] len,
                                    input logic [BYTE_W-1:0] dat,
                                    input logic step_last, input logic fin);
        t_cmd c;
        c.rep       = rep;
        c.len       = len;
        c.dat       = dat;
        c.step_last = step_last;
        c.fin       = fin;
        return c;
    endfunction

endpackage

`default_nettype wire

### src/rleb_ram.sv
// ----------------------------------------------------------------------------
// rleb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/rleb_front.sv
// ----------------------------------------------------------------------------
// rleb_front
// takes input items, writes bytes to the ring, decides runs
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_front import rleb_pkg::*; #(
    parameter int MAX_RUN      = 128,
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [BYTE_W-1:0]               i_in_byte,
    input  wire logic                            i_in_last,
    input  wire logic                            i_q_room,
    input  wire logic [LEN_W-1:0]                i_freed,
    output logic [1:0]                           o_push_n,
    output t_cmd                                 o_c0,
    output t_cmd                                 o_c1,
    output logic                                 o_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      o_waddr
);

    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int UW = $clog2(BUFFER_DEPTH + 1);

    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_rep, n_rep;
    logic [BYTE_W-1:0] r_head, n_head;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [AW-1:0]     r_wr;
    logic [UW-1:0]     r_used;
    logic              accept;
    logic              fin;
    logic              same_h;
    logic              same_p;
    logic [LEN_W-1:0]  cl;

    assign o_in_stall = !i_q_room || (r_used == UW'(BUFFER_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign o_we       = accept;
    assign o_waddr    = r_wr;
    assign fin        = i_in_last;
    assign same_h     = (i_in_byte == r_head);
    assign same_p     = (i_in_byte == r_prev);
    assign cl         = LEN_W'(r_cnt);

    always_comb begin
        n_cnt    = r_cnt;
        n_rep    = r_rep;
        n_head   = r_head;
        n_prev   = r_prev;
        o_c0     = '0;
        o_c1     = '0;
        o_push_n = 2'd0;
        if (accept) begin
            n_prev = i_in_byte;
            priority if (r_cnt == '0) begin
                if (fin) begin
                    o_c0 = mk_cmd(1'b0, LEN_W'(1), i_in_byte, 1'b1, fin);
                    o_push_n = 2'd1;
                end else begin
                    n_cnt  = CW'(1);
                    n_head = i_in_byte;
                end
            end else if (r_cnt == CW'(1)) begin
                if (fin) begin
                    o_c0 = mk_cmd(same_h, LEN_W'(2), r_head, 1'b1, fin);
                    o_push_n = 2'd1;
                end else begin
                    n_cnt = CW'(2);
                    n_rep = same_h;
                end
            end else if (r_cnt == CW'(MAX_RUN)) begin
                // full run closes whatever the new byte is; a last byte instead takes the run's final byte into a pair
                if (fin) begin
                    o_c0 = mk_cmd(r_rep, LEN_W'(MAX_RUN - 1), r_head, 1'b0, fin);
                    o_c1 = mk_cmd(r_rep ? same_h : same_p, LEN_W'(2),
                                  r_rep ? r_head : r_prev, 1'b1, fin);
                    o_push_n = 2'd2;
                end else begin
                    o_c0 = mk_cmd(r_rep, LEN_W'(MAX_RUN), r_head, 1'b1, fin);
                    o_push_n = 2'd1;
                    n_cnt  = CW'(1);
                    n_head = i_in_byte;
                end
            end else if (r_rep) begin
                if (same_h) begin
                    n_cnt = r_cnt + CW'(1);
                    if (fin) begin
                        o_c0 = mk_cmd(1'b1, cl + LEN_W'(1), r_head, 1'b1, fin);
                        o_push_n = 2'd1;
                    end
                end else if (!fin) begin
                    o_c0 = mk_cmd(1'b1, cl, r_head, 1'b1, fin);
                    o_push_n = 2'd1;
                    n_cnt  = CW'(1);
                    n_head = i_in_byte;
                end else if (r_cnt == CW'(2)) begin
                    // pair plus a lone last byte becomes one literal of three
                    o_c0 = mk_cmd(1'b0, LEN_W'(3), r_head, 1'b1, fin);
                    o_push_n = 2'd1;
                end else begin
                    o_c0 = mk_cmd(1'b1, cl - LEN_W'(1), r_head, 1'b0, fin);
                    o_c1 = mk_cmd(1'b0, LEN_W'(2), r_head, 1'b1, fin);
                    o_push_n = 2'd2;
                end
            end else begin
                if (!same_p) begin
                    n_cnt = r_cnt + CW'(1);
                    if (fin) begin
                        o_c0 = mk_cmd(1'b0, cl + LEN_W'(1), r_head, 1'b1, fin);
                        o_push_n = 2'd1;
                    end
                end else if (r_cnt == CW'(2)) begin
                    if (fin) begin
                        o_c0 = mk_cmd(1'b0, LEN_W'(3), r_head, 1'b1, fin);
                    end else begin
                        o_c0 = mk_cmd(1'b0, LEN_W'(2), r_head, 1'b1, fin);
                        n_cnt  = CW'(1);
                        n_head = i_in_byte;
                    end
                    o_push_n = 2'd1;
                end else begin
                    // literal gives up its final byte to the equal pair
                    if (fin) begin
                        o_c0 = mk_cmd(1'b0, cl - LEN_W'(1), r_head, 1'b0, fin);
                        o_c1 = mk_cmd(1'b1, LEN_W'(2), r_prev, 1'b1, fin);
                        o_push_n = 2'd2;
                    end else begin
                        o_c0 = mk_cmd(1'b0, cl - LEN_W'(1), r_head, 1'b1, fin);
                        o_push_n = 2'd1;
                        n_cnt  = CW'(2);
                        n_rep  = 1'b1;
                        n_head = r_prev;
                    end
                end
            end
            if (fin) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rep  <= 1'b0;
            r_head <= '0;
            r_prev <= '0;
            r_wr   <= '0;
            r_used <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_rep  <= n_rep;
            r_head <= n_head;
            r_prev <= n_prev;
            r_used <= r_used + UW'(accept) - UW'(i_freed);
            if (accept) begin
                r_wr <= (r_wr == AW'(BUFFER_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
        end
    end

    a_fin_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && fin |=> r_cnt == '0)
        else $error("pending run not cleared after last byte");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(BUFFER_DEPTH))
        else $error("ring occupancy overflow");

endmodule

`default_nettype wire

### src/rleb_cmdq.sv
// ----------------------------------------------------------------------------
// rleb_cmdq
// four entry run queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_cmdq import rleb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  t_cmd            i_c0,
    input  t_cmd            i_c1,
    output logic            o_room,
    input  wire logic       i_pop,
    output logic            o_nonempty,
    output t_cmd            o_head
);

    t_cmd       r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;

    assign o_room     = (r_cnt <= 3'd2);
    assign o_nonempty = (r_cnt != 3'd0);
    assign o_head     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[r_wp] <= i_c0;
        end
        if (i_push_n == 2'd2) begin
            r_q[r_wp + 2'd1] <= i_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_rp  <= r_rp + 2'(i_pop);
            r_cnt <= r_cnt + 3'(i_push_n) - 3'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (3'(i_push_n) + r_cnt) <= 3'd4 + 3'(i_pop))
        else $error("run queue overflow");

endmodule

`default_nettype wire

### src/rleb_back.sv
// ----------------------------------------------------------------------------
// rleb_back
// turns runs into header and data bytes and packs them up to eight to a result
// ----------------------------------------------------------------------------
`default_nettype none

module rleb_back import rleb_pkg::*; #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_nonempty,
    input  t_cmd                             i_q_head,
    output logic                             o_q_pop,
    output logic                             o_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0]  o_raddr,
    input  wire logic [BYTE_W-1:0]           i_rdata,
    output logic [LEN_W-1:0]                 o_freed,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [63:0]                      o_out_bytes,
    output logic [3:0]                       o_out_count,
    output logic                             o_burst_last,
    output logic                             o_stream_end
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_LIT  = 2'd2;
    localparam logic [1:0] S_REP  = 2'd3;

    logic [1:0]        r_st;
    t_cmd              r_cmd;
    logic [LEN_W-1:0]  r_rem;
    logic [AW-1:0]     r_rd;
    logic [63:0]       r_acc;
    logic [2:0]        r_acnt;
    logic [63:0]       r_obytes;
    logic [3:0]        r_ocnt;
    logic              r_olast;
    logic              r_oend;
    logic              r_ovalid;

    logic              emit;
    logic [BYTE_W-1:0] ebyte;
    logic              elast;
    logic              flush;
    logic              fire;
    logic [63:0]       acc_new;
    logic [AW-1:0]     rd_inc;
    logic [AW:0]       rd_sum;
    logic [AW-1:0]     rd_skip;

    assign rd_inc  = (r_rd == AW'(BUFFER_DEPTH - 1)) ? '0 : r_rd + AW'(1);
    assign rd_sum  = (AW+1)'(r_rd) + (AW+1)'(r_cmd.len);
    assign rd_skip = (rd_sum >= (AW+1)'(BUFFER_DEPTH))
                   ? AW'(rd_sum - (AW+1)'(BUFFER_DEPTH)) : AW'(rd_sum);

    always_comb begin
        emit  = 1'b0;
        ebyte = '0;
        elast = 1'b0;
        unique case (r_st)
            S_IDLE: emit = 1'b0;
            S_HDR: begin
                emit  = 1'b1;
                ebyte = r_cmd.rep ? BYTE_W'(9'd257 - 9'(r_cmd.len))
                                  : BYTE_W'(r_cmd.len - LEN_W'(1));
            end
            S_LIT: begin
                emit  = 1'b1;
                ebyte = i_rdata;
                elast = r_cmd.step_last && (r_rem == LEN_W'(1));
            end
            S_REP: begin
                emit  = 1'b1;
                ebyte = r_cmd.dat;
                elast = r_cmd.step_last;
            end
            default: emit = 1'b0;
        endcase
    end

    assign flush   = emit && ((r_acnt == 3'd7) || elast);
    assign fire    = emit && (!flush || !r_ovalid || !i_out_stall);
    assign o_q_pop = (r_st == S_IDLE) && i_q_nonempty;

    always_comb begin
        acc_new = r_acc;
        acc_new[r_acnt*8 +: 8] = ebyte;
    end

    always_comb begin
        o_re    = 1'b0;
        o_raddr = r_rd;
        o_freed = '0;
        if (fire) begin
            if ((r_st == S_HDR) && !r_cmd.rep) begin
                o_re = 1'b1;
            end
            if (r_st == S_LIT) begin
                o_freed = LEN_W'(1);
                o_raddr = rd_inc;
                o_re    = (r_rem != LEN_W'(1));
            end
            if (r_st == S_REP) begin
                o_freed = r_cmd.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_head;
        end
        if (fire && (r_st == S_HDR)) begin
            r_rem <= r_cmd.len;
        end else if (fire && (r_st == S_LIT)) begin
            r_rem <= r_rem - LEN_W'(1);
        end
        if (fire && flush) begin
            r_obytes <= acc_new;
            r_ocnt   <= 4'(r_acnt) + 4'd1;
            r_olast  <= elast;
            r_oend   <= elast && r_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_rd     <= '0;
            r_acc    <= '0;
            r_acnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (fire && flush) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (fire) begin
                if (flush) begin
                    r_acc  <= '0;
                    r_acnt <= '0;
                end else begin
                    r_acc  <= acc_new;
                    r_acnt <= r_acnt + 3'd1;
                end
            end
            unique case (r_st)
                S_IDLE: if (o_q_pop) r_st <= S_HDR;
                S_HDR: if (fire) r_st <= r_cmd.rep ? S_REP : S_LIT;
                S_LIT: if (fire) begin
                    r_rd <= rd_inc;
                    if (r_rem == LEN_W'(1)) r_st <= S_IDLE;
                end
                S_REP: if (fire) begin
                    r_rd <= rd_skip;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_bytes  = r_obytes;
    assign o_out_count  = r_ocnt;
    assign o_burst_last = r_olast;
    assign o_stream_end = r_oend;

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_ocnt != 4'd0) && (r_ocnt <= 4'd8))
        else $error("result with bad lane count");

    a_lit_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LIT) |-> (r_rem != '0))
        else $error("literal state with nothing left");

endmodule

`default_nettype wire

### src/run_length_byte_encoder.sv
// a decided run passes through the run queue and the back end's header state into the output register
// throughput: one input item per cycle while the ring and run queue have room
// back end emits one encoded byte per cycle unless held by output stall, with an idle state between runs
// literal bytes come out of the ring ram, one read per cycle unless held by output stall
// reset: synchronous active low, clears run state, pointers, queue and output
// ----------------------------------------------------------------------------
// run_length_byte_encoder
// literal / replicate run-length encoder, results packed up to eight bytes
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_byte_encoder import rleb_pkg::*; #(
    parameter int MAX_RUN      = 128,
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_out_bytes,
    output logic [3:0]       o_out_count,
    output logic             o_burst_last,
    output logic             o_stream_end
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    // front to queue
    logic [1:0]        push_n;
    t_cmd              c0;
    t_cmd              c1;
    logic              q_room;
    // queue to back
    logic              q_nonempty;
    logic              q_pop;
    t_cmd              q_head;
    // ring ram ports
    logic              we;
    logic [AW-1:0]     waddr;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rdata;
    // bytes given back to the ring by the back end
    logic [LEN_W-1:0]  freed;

    // front: every byte goes to the ring, runs are decided here
    rleb_front #(
        .MAX_RUN      (MAX_RUN),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_room   (q_room),
        .i_freed    (freed),
        .o_push_n   (push_n),
        .o_c0       (c0),
        .o_c1       (c1),
        .o_we       (we),
        .o_waddr    (waddr)
    );

    // decided runs wait here so each side can stall on its own
    rleb_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_c0       (c0),
        .i_c1       (c1),
        .o_room     (q_room),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // ring of raw bytes, literal runs read back from here
    rleb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_byte),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // back: header and data bytes, packing and output register
    rleb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_freed      (freed),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_bytes  (o_out_bytes),
        .o_out_count  (o_out_count),
        .o_burst_last (o_burst_last),
        .o_stream_end (o_stream_end)
    );

endmodule

`default_nettype wire
